>>> hw/rtl/matrix_inverse_gauss_pivot_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the matrix inverse block
// Implication checks clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef MATRIX_INVERSE_GAUSS_PIVOT_TOP_MACROS_SVH
`define MATRIX_INVERSE_GAUSS_PIVOT_TOP_MACROS_SVH

// same-cycle implication
`define MIG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MIG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/mig_pkg.sv
// ----------------------------------------------------------------------------
// mig_pkg
// Shared types, constants and fixed-point helpers for the matrix inverse.
// ----------------------------------------------------------------------------
package mig_pkg;

  localparam int MAX_DIM_DEF = 8;
  localparam int FX_W        = 48;
  localparam int ELEM_W      = 32;
  localparam int SIZE_W      = 4;
  localparam int THR_W       = 16;

  typedef logic signed [FX_W-1:0] fx_t;

  localparam fx_t FX_MAX  = 48'sh7FFF_FFFF_FFFF;
  localparam fx_t FX_MIN  = 48'sh8000_0000_0000;
  localparam fx_t ONE_Q16 = 48'sh0000_0001_0000;
  localparam logic [48:0] MAG_CAP = 49'h1_0000_0000_0000;

  // register word indexes
  localparam logic REG_SIZE = 1'b0;
  localparam logic REG_THR  = 1'b1;

  typedef enum logic {OP_MUL, OP_DIV} arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

  typedef struct packed {
    logic done;
    fx_t  value;
  } arith_rsp_t;

  function automatic logic [FX_W-1:0] mag48(input fx_t v);
    logic [FX_W-1:0] u;
    u = v;
    return u[FX_W-1] ? (~u + 48'd1) : u;
  endfunction

  function automatic fx_t signed_of(input logic [48:0] m, input logic neg);
    if (neg) begin
      if (m > 49'h0_8000_0000_0000) return FX_MIN;
      return fx_t'(~m[47:0] + 48'd1);
    end
    if (m > 49'h0_7FFF_FFFF_FFFF) return FX_MAX;
    return fx_t'(m[47:0]);
  endfunction

  function automatic fx_t sat_sub(input fx_t a, input fx_t b);
    logic [48:0] d;
    d = {a[47], a} - {b[47], b};
    if (d[48] != d[47]) return d[48] ? FX_MIN : FX_MAX;
    return fx_t'(d[47:0]);
  endfunction

  function automatic fx_t sat_add(input fx_t a, input fx_t b);
    logic [48:0] d;
    d = {a[47], a} + {b[47], b};
    if (d[48] != d[47]) return d[48] ? FX_MIN : FX_MAX;
    return fx_t'(d[47:0]);
  endfunction

  function automatic logic [ELEM_W-1:0] out32(input fx_t v);
    if (!v[47] && (v[46:31] != 16'h0000)) return 32'h7FFF_FFFF;
    if (v[47] && (v[46:31] != 16'hFFFF)) return 32'h8000_0000;
    return v[31:0];
  endfunction

endpackage

>>> hw/rtl/mig_ram.sv
// ----------------------------------------------------------------------------
// mig_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module mig_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> hw/rtl/mig_arith.sv
// ----------------------------------------------------------------------------
// mig_arith
// Shared Q32.16 multiply (four 24x24 partial products) and divide
// (restoring, one quotient bit per cycle), both with rounding and saturation.
// ----------------------------------------------------------------------------
module mig_arith import mig_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  arith_req_t req,
  input  fx_t        opa,
  input  fx_t        opb,
  output arith_rsp_t rsp
);

  typedef enum logic [2:0] {A_IDLE, A_MUL, A_MFIN, A_DIV, A_DFIN} astate_t;

  astate_t     st;
  logic [47:0] ma, mb;
  logic        neg;
  logic [95:0] prod;
  logic [63:0] num;
  logic [47:0] rem;
  logic [5:0]  step;

  logic [47:0] ma_in, mb_in;
  logic [23:0] pa, pb;
  logic [47:0] pp;
  logic [95:0] pp_sh;
  logic [48:0] shifted;
  logic [49:0] diff;
  logic        qbit;
  logic [95:0] rnd;
  logic [48:0] mcap, dcap;

  always_comb begin
    ma_in   = mag48(opa);
    mb_in   = mag48(opb);
    pa      = step[1] ? ma[47:24] : ma[23:0];
    pb      = step[0] ? mb[47:24] : mb[23:0];
    pp      = pa * pb;
    case (step[1:0])
      2'd0:    pp_sh = {48'd0, pp};
      2'd3:    pp_sh = {pp, 48'd0};
      default: pp_sh = {24'd0, pp, 24'd0};
    endcase
    shifted = {rem, num[63]};
    diff    = {1'b0, shifted} - {2'b00, mb};
    qbit    = !diff[49];
    rnd     = prod + 96'h8000;
    mcap    = (rnd[95:16] > {31'd0, MAG_CAP}) ? MAG_CAP : rnd[64:16];
    dcap    = (num > {15'd0, MAG_CAP}) ? MAG_CAP : num[48:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= A_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      case (st)
        A_IDLE: begin
          if (req.start) begin
            ma   <= ma_in;
            mb   <= mb_in;
            neg  <= opa[47] ^ opb[47];
            step <= '0;
            prod <= '0;
            rem  <= '0;
            num  <= {ma_in, 16'h0000} + {17'd0, mb_in[47:1]};
            if (req.op == OP_MUL) begin
              st <= A_MUL;
            end else if (mb_in == '0) begin
              rsp.done  <= 1'b1;
              rsp.value <= (opa == '0) ? '0 : (opa[47] ? FX_MIN : FX_MAX);
            end else begin
              st <= A_DIV;
            end
          end
        end
        A_MUL: begin
          prod <= prod + pp_sh;
          step <= step + 6'd1;
          if (step[1:0] == 2'd3) begin
            st <= A_MFIN;
          end
        end
        A_MFIN: begin
          rsp.done  <= 1'b1;
          rsp.value <= signed_of(mcap, neg);
          st        <= A_IDLE;
        end
        A_DIV: begin
          rem  <= qbit ? diff[47:0] : shifted[47:0];
          num  <= {num[62:0], qbit};
          step <= step + 6'd1;
          if (step == 6'd63) begin
            st <= A_DFIN;
          end
        end
        A_DFIN: begin
          rsp.done  <= 1'b1;
          rsp.value <= signed_of(dcap, neg);
          st        <= A_IDLE;
        end
        default: st <= A_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/mig_seq.sv
// ----------------------------------------------------------------------------
// mig_seq
// Sequencer: loads the matrix, runs pivoted elimination and back substitution
// over the work and augmented memories, then streams the inverse out or flags a singular pivot.
// ----------------------------------------------------------------------------
module mig_seq import mig_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [SIZE_W-1:0]        matrix_size,
  input  logic [THR_W-1:0]         pivot_threshold,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [ELEM_W-1:0] element,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [ELEM_W-1:0] inverse_element,
  output logic                     singular,
  output logic                     last_of_run,
  output arith_req_t               areq,
  output fx_t                      opa,
  output fx_t                      opb,
  input  arith_rsp_t               arsp
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int IW    = $clog2(MAX_DIM);
  localparam int CW    = $clog2(MAX_DIM + 1);
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = $clog2(DEPTH + 1);

  typedef enum logic [4:0] {
    ST_LOAD, ST_INIT, ST_SCAN_RD, ST_SCAN_CMP, ST_SWAP_RD, ST_SWAP_W1, ST_SWAP_W2,
    ST_PIV_RD, ST_PIV_CHK, ST_F_RD, ST_F_DIV, ST_F_WAIT, ST_E_RD, ST_E_MULA,
    ST_E_WA, ST_E_MULG, ST_E_WG, ST_BK_LAST_RD, ST_BK_LAST_DIV, ST_BK_LAST_WAIT,
    ST_BK_ACC_RD, ST_BK_ACC_MUL, ST_BK_ACC_WAIT, ST_BK_X_RD, ST_BK_X_DIV,
    ST_BK_X_WAIT, ST_EM_RD, ST_EM_LD, ST_EM_WAIT
  } state_t;

  function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] row,
                                            input logic [IW-1:0] col,
                                            input logic [CW-1:0] n);
    return AW'(row) * AW'(n) + AW'(col);
  endfunction

  state_t         state;
  logic [LW-1:0]  load_count, idx;
  logic [CW-1:0]  n_r;
  logic [IW-1:0]  j, r, i, k, p;
  logic [47:0]    best;
  fx_t            piv, f, acc, ar, gr, gj, ta, tg;

  logic           a_we, g_we;
  logic [AW-1:0]  a_waddr, g_waddr, a_ra, a_rb, g_ra, g_rb;
  fx_t            a_wdata, g_wdata, a_qa, a_qb, g_qa, g_qb;

  logic [CW-1:0]  n_now;
  logic [LW-1:0]  cells_now, cells_r, cnt_inc;
  logic [IW-1:0]  last;
  logic [47:0]    scan_mag;
  logic           scan_upd;
  logic [IW-1:0]  p_sel;

  mig_ram #(.WIDTH(FX_W), .DEPTH(DEPTH)) u_work (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr_a(a_ra), .raddr_b(a_rb), .rdata_a(a_qa), .rdata_b(a_qb)
  );

  mig_ram #(.WIDTH(FX_W), .DEPTH(DEPTH)) u_aug (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .raddr_a(g_ra), .raddr_b(g_rb), .rdata_a(g_qa), .rdata_b(g_qb)
  );

  assign in_stall = (state != ST_LOAD);

  always_comb begin
    if (matrix_size == '0) begin
      n_now = CW'(1);
    end else if (int'(matrix_size) > MAX_DIM) begin
      n_now = CW'(MAX_DIM);
    end else begin
      n_now = CW'(matrix_size);
    end
    cells_now = LW'(LW'(n_now) * LW'(n_now));
    cells_r   = LW'(LW'(n_r) * LW'(n_r));
    cnt_inc   = load_count + LW'(1);
    last      = IW'(n_r - CW'(1));
    scan_mag  = mag48(a_qa);
    scan_upd  = best < scan_mag;
    p_sel     = scan_upd ? r : p;
  end

  // memory ports and arithmetic requests; every write lands before the next
  // dependent read is issued
  always_comb begin
    a_we = 1'b0; a_waddr = '0; a_wdata = '0; a_ra = '0; a_rb = '0;
    g_we = 1'b0; g_waddr = '0; g_wdata = '0; g_ra = '0; g_rb = '0;
    areq.start = 1'b0; areq.op = OP_MUL; opa = '0; opb = '0;
    case (state)
      ST_LOAD: begin
        a_we    = in_valid;
        a_waddr = load_count[AW-1:0];
        a_wdata = {{(FX_W-ELEM_W){element[ELEM_W-1]}}, element};
      end
      ST_INIT: begin
        g_we    = 1'b1;
        g_waddr = addr_of(r, i, n_r);
        g_wdata = (r == i) ? ONE_Q16 : '0;
      end
      ST_SCAN_RD: a_ra = addr_of(r, j, n_r);
      ST_SWAP_RD: begin
        a_ra = addr_of(p, i, n_r); a_rb = addr_of(j, i, n_r);
        g_ra = addr_of(p, i, n_r); g_rb = addr_of(j, i, n_r);
      end
      ST_SWAP_W1: begin
        a_we = 1'b1; a_waddr = addr_of(j, i, n_r); a_wdata = a_qa;
        g_we = 1'b1; g_waddr = addr_of(j, i, n_r); g_wdata = g_qa;
      end
      ST_SWAP_W2: begin
        a_we = 1'b1; a_waddr = addr_of(p, i, n_r); a_wdata = ta;
        g_we = 1'b1; g_waddr = addr_of(p, i, n_r); g_wdata = tg;
      end
      ST_PIV_RD: a_ra = addr_of(j, j, n_r);
      ST_F_RD:   a_ra = addr_of(r, j, n_r);
      ST_F_DIV: begin
        areq.start = 1'b1; areq.op = OP_DIV; opa = a_qa; opb = piv;
      end
      ST_E_RD: begin
        a_ra = addr_of(r, i, n_r); a_rb = addr_of(j, i, n_r);
        g_ra = addr_of(r, i, n_r); g_rb = addr_of(j, i, n_r);
      end
      ST_E_MULA: begin
        areq.start = 1'b1; opa = f; opb = a_qb;
      end
      ST_E_WA: begin
        a_we = arsp.done; a_waddr = addr_of(r, i, n_r); a_wdata = sat_sub(ar, arsp.value);
      end
      ST_E_MULG: begin
        areq.start = 1'b1; opa = f; opb = gj;
      end
      ST_E_WG: begin
        g_we = arsp.done; g_waddr = addr_of(r, i, n_r); g_wdata = sat_sub(gr, arsp.value);
      end
      ST_BK_LAST_RD: begin
        g_ra = addr_of(last, k, n_r); a_ra = addr_of(last, last, n_r);
      end
      ST_BK_LAST_DIV: begin
        areq.start = 1'b1; areq.op = OP_DIV; opa = g_qa; opb = a_qa;
      end
      ST_BK_LAST_WAIT: begin
        g_we = arsp.done; g_waddr = addr_of(last, k, n_r); g_wdata = arsp.value;
      end
      ST_BK_ACC_RD: begin
        a_ra = addr_of(j, i, n_r); g_ra = addr_of(i, k, n_r);
      end
      ST_BK_ACC_MUL: begin
        areq.start = 1'b1; opa = a_qa; opb = g_qa;
      end
      ST_BK_X_RD: begin
        g_ra = addr_of(j, k, n_r); a_ra = addr_of(j, j, n_r);
      end
      ST_BK_X_DIV: begin
        areq.start = 1'b1; areq.op = OP_DIV; opa = sat_sub(g_qa, acc); opb = a_qa;
      end
      ST_BK_X_WAIT: begin
        g_we = arsp.done; g_waddr = addr_of(j, k, n_r); g_wdata = arsp.value;
      end
      ST_EM_RD: g_ra = idx[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      load_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (in_valid) begin
            if (cnt_inc >= cells_now) begin
              load_count <= '0;
              n_r        <= n_now;
              r          <= '0;
              i          <= '0;
              state      <= ST_INIT;
            end else begin
              load_count <= cnt_inc;
            end
          end
        end
        ST_INIT: begin
          if (i == last) begin
            i <= '0;
            if (r == last) begin
              j <= '0; r <= '0; p <= '0; best <= '0;
              state <= ST_SCAN_RD;
            end else begin
              r <= r + IW'(1);
            end
          end else begin
            i <= i + IW'(1);
          end
        end
        ST_SCAN_RD: state <= ST_SCAN_CMP;
        ST_SCAN_CMP: begin
          if (scan_upd) begin
            best <= scan_mag;
          end
          p <= p_sel;
          if (r == last) begin
            i     <= '0;
            state <= (p_sel == j) ? ST_PIV_RD : ST_SWAP_RD;
          end else begin
            r     <= r + IW'(1);
            state <= ST_SCAN_RD;
          end
        end
        ST_SWAP_RD: state <= ST_SWAP_W1;
        ST_SWAP_W1: begin
          ta    <= a_qb;
          tg    <= g_qb;
          state <= ST_SWAP_W2;
        end
        ST_SWAP_W2: begin
          if (i == last) begin
            state <= ST_PIV_RD;
          end else begin
            i     <= i + IW'(1);
            state <= ST_SWAP_RD;
          end
        end
        ST_PIV_RD: state <= ST_PIV_CHK;
        ST_PIV_CHK: begin
          piv <= a_qa;
          if (mag48(a_qa) <= {32'd0, pivot_threshold}) begin
            out_valid       <= 1'b1;
            inverse_element <= '0;
            singular        <= 1'b1;
            last_of_run     <= 1'b1;
            state           <= ST_EM_WAIT;
          end else if (j == last) begin
            k     <= '0;
            state <= ST_BK_LAST_RD;
          end else begin
            r     <= j + IW'(1);
            state <= ST_F_RD;
          end
        end
        ST_F_RD:  state <= ST_F_DIV;
        ST_F_DIV: state <= ST_F_WAIT;
        ST_F_WAIT: begin
          if (arsp.done) begin
            f     <= arsp.value;
            i     <= '0;
            state <= ST_E_RD;
          end
        end
        ST_E_RD: state <= ST_E_MULA;
        ST_E_MULA: begin
          ar    <= a_qa;
          gr    <= g_qa;
          gj    <= g_qb;
          state <= ST_E_WA;
        end
        ST_E_WA: begin
          if (arsp.done) begin
            state <= ST_E_MULG;
          end
        end
        ST_E_MULG: state <= ST_E_WG;
        ST_E_WG: begin
          if (arsp.done) begin
            if (i != last) begin
              i     <= i + IW'(1);
              state <= ST_E_RD;
            end else if (r != last) begin
              r     <= r + IW'(1);
              state <= ST_F_RD;
            end else begin
              j     <= j + IW'(1);
              r     <= j + IW'(1);
              p     <= j + IW'(1);
              best  <= '0;
              state <= ST_SCAN_RD;
            end
          end
        end
        ST_BK_LAST_RD:  state <= ST_BK_LAST_DIV;
        ST_BK_LAST_DIV: state <= ST_BK_LAST_WAIT;
        ST_BK_LAST_WAIT: begin
          if (arsp.done) begin
            if (last == '0) begin
              idx   <= '0;
              state <= ST_EM_RD;
            end else begin
              j     <= last - IW'(1);
              i     <= last;
              acc   <= '0;
              state <= ST_BK_ACC_RD;
            end
          end
        end
        ST_BK_ACC_RD:  state <= ST_BK_ACC_MUL;
        ST_BK_ACC_MUL: state <= ST_BK_ACC_WAIT;
        ST_BK_ACC_WAIT: begin
          if (arsp.done) begin
            acc <= sat_add(acc, arsp.value);
            if (i == last) begin
              state <= ST_BK_X_RD;
            end else begin
              i     <= i + IW'(1);
              state <= ST_BK_ACC_RD;
            end
          end
        end
        ST_BK_X_RD:  state <= ST_BK_X_DIV;
        ST_BK_X_DIV: state <= ST_BK_X_WAIT;
        ST_BK_X_WAIT: begin
          if (arsp.done) begin
            if (j != '0) begin
              j     <= j - IW'(1);
              i     <= j;
              acc   <= '0;
              state <= ST_BK_ACC_RD;
            end else if (k == last) begin
              idx   <= '0;
              state <= ST_EM_RD;
            end else begin
              k     <= k + IW'(1);
              state <= ST_BK_LAST_RD;
            end
          end
        end
        ST_EM_RD: state <= ST_EM_LD;
        ST_EM_LD: begin
          out_valid       <= 1'b1;
          inverse_element <= out32(g_qa);
          singular        <= 1'b0;
          last_of_run     <= (idx == cells_r - LW'(1));
          state           <= ST_EM_WAIT;
        end
        ST_EM_WAIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (last_of_run) begin
              state <= ST_LOAD;
            end else begin
              idx   <= idx + LW'(1);
              state <= ST_EM_RD;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule

>>> hw/rtl/matrix_inverse_gauss_pivot_top.sv
// ----------------------------------------------------------------------------
// matrix_inverse_gauss_pivot_top
// Q16.16 matrix inverse by Gaussian elimination with partial pivoting.
// ----------------------------------------------------------------------------
// Elements stream in row-major, one beat per cycle, while the block is
// loading. On the last element of an N x N matrix the input stalls while the
// block pivots, eliminates and back-substitutes in place in two 64 x 48-bit
// memories, all through one shared arithmetic unit that serves one multiply
// or divide at a time. Each elimination update takes two multiplies and each
// row factor a divide; back substitution takes a multiply per product and a
// divide per unknown. The inverse then leaves row-major, one beat at a time,
// held while out_stall is high, with last_of_run on the final beat; a
// singular matrix gives one zero beat with singular and last_of_run set. No
// clearing pass after reset.
// ----------------------------------------------------------------------------
`include "matrix_inverse_gauss_pivot_top_macros.svh"

module matrix_inverse_gauss_pivot_top import mig_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [ELEM_W-1:0] element,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [ELEM_W-1:0] inverse_element,
  output logic                     singular,
  output logic                     last_of_run
);

  logic [SIZE_W-1:0] matrix_size;
  logic [THR_W-1:0]  pivot_threshold;
  arith_req_t        areq;
  arith_rsp_t        arsp;
  fx_t               opa, opb;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size     <= SIZE_W'(4);
      pivot_threshold <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_SIZE: matrix_size     <= pwdata[SIZE_W-1:0];
        REG_THR:  pivot_threshold <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SIZE: prdata = {{(32-SIZE_W){1'b0}}, matrix_size};
      REG_THR:  prdata = {{(32-THR_W){1'b0}}, pivot_threshold};
      default:  prdata = '0;
    endcase
  end

  mig_arith u_arith (
    .clk(clk), .rst(rst), .req(areq), .opa(opa), .opb(opb), .rsp(arsp)
  );

  mig_seq #(.MAX_DIM(MAX_DIM)) u_seq (
    .clk(clk), .rst(rst),
    .matrix_size(matrix_size), .pivot_threshold(pivot_threshold),
    .in_valid(in_valid), .in_stall(in_stall), .element(element),
    .out_valid(out_valid), .out_stall(out_stall),
    .inverse_element(inverse_element), .singular(singular),
    .last_of_run(last_of_run),
    .areq(areq), .opa(opa), .opb(opb), .arsp(arsp)
  );

  `MIG_ASSERT_IMP(a_sing_last, out_valid && singular, last_of_run && (inverse_element == '0), "singular beat not last or not zero")
  `MIG_ASSERT_IMP(a_no_overlap, in_valid && !in_stall, !out_valid, "input taken while result pending")
  `MIG_ASSERT_NXT(a_reopen, out_valid && !out_stall && last_of_run, !in_stall, "input not reopened after last beat")

endmodule
